/* design/nrmc_pkg.sv */
// ----------------------------------------------------------------------------
// nrmc_pkg
// Types, constants and per-character parse functions shared by the RMC
// sentence parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package nrmc_pkg;

    localparam int MINUTE_FIELD_CHARS_DEF = 7;
    localparam int MAX_FIELD_CHARS_DEF    = 16;

    localparam logic [31:0] LAT_LIMIT = 32'd900000000;
    localparam logic [31:0] LON_LIMIT = 32'd1800000000;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    localparam logic [5:0][7:0] HDR_TEXT = {8'h43, 8'h4D, 8'h52, 8'h50, 8'h47, 8'h24};

    // Field numbers of the sentence.
    localparam logic [3:0] FLD_HEADER = 4'd0;
    localparam logic [3:0] FLD_UTC    = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_NS     = 4'd4;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_EW     = 4'd6;
    localparam logic [3:0] FLD_SPEED  = 4'd7;
    localparam logic [3:0] FLD_COURSE = 4'd8;
    localparam logic [3:0] FLD_DATE   = 4'd9;
    localparam logic [3:0] FLD_MAGVAR = 4'd10;
    localparam logic [3:0] FLD_MAX    = 4'd15;

    localparam logic [4:0][19:0] NUM_CAP =
        {20'd18000, 20'd524287, 20'd36000, 20'd99999, 20'd262143};
    localparam logic [4:0] NUM_HUND = 5'b10110;

    // Reciprocal of 60 scaled by 2^36, exact for dividends below 2^30.
    localparam int          RECIP_SHIFT = 36;
    localparam logic [30:0] RECIP_60    = 31'd1145324613;
    localparam logic [23:0] DEG_SCALE   = 24'd10000000;

    typedef struct packed {
        logic [7:0]  deg;
        logic [19:0] minute;
        logic [2:0]  frac_digits;
        logic        neg;
    } coord_t;

    typedef struct packed {
        logic [3:0]       field_index;
        logic [4:0]       char_in_field;
        logic             header_ok;
        logic             status_ok;
        logic [7:0]       running_xor;
        logic             after_star;
        logic [1:0][7:0]  degree_accum;
        logic [1:0][19:0] minute_accum;
        logic [1:0][2:0]  coord_frac;
        logic [2:0]       fraction_digits;
        logic             point_seen;
        logic [4:0][19:0] number_accum;
        logic [1:0]       hemisphere_neg;
        logic [1:0]       coord_ok;
    } pstate_t;

    typedef struct packed {
        logic        valid;
        logic [17:0] utc_time;
        coord_t      lat;
        coord_t      lon;
        logic [16:0] speed_knots;
        logic [15:0] true_course;
        logic [18:0] date_value;
        logic [14:0] mag_variation;
        logic [7:0]  checksum;
    } record_t;

    function automatic pstate_t clear_state();
        pstate_t s;
        s           = '0;
        s.header_ok = 1'b1;
        return s;
    endfunction

    // Quotient by ten of a value below 100.
    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [14:0] p;
        p = v * 8'd205;
        return p[14:11];
    endfunction

    // 10 to the power of (7 - fd), the scale that brings minutes to 1e-7 units.
    function automatic logic [23:0] minute_scale(input logic [2:0] fd);
        logic [23:0] r;
        case (fd)
            3'd0:    r = 24'd10000000;
            3'd1:    r = 24'd1000000;
            3'd2:    r = 24'd100000;
            3'd3:    r = 24'd10000;
            default: r = 24'd1000;
        endcase
        return r;
    endfunction

    function automatic pstate_t field_end(input pstate_t si, input int mfc);
        pstate_t s;
        logic    k;
        s = si;
        k = (s.field_index == FLD_LON);
        if (s.field_index == FLD_HEADER && s.char_in_field != 5'd6)
            s.header_ok = 1'b0;
        if (s.field_index == FLD_STATUS && s.char_in_field != 5'd1)
            s.status_ok = 1'b0;
        if (s.field_index == FLD_LAT || s.field_index == FLD_LON) begin
            s.coord_ok[k]   = (32'(s.char_in_field) >= 32'(mfc));
            s.coord_frac[k] = s.fraction_digits;
            if (32'(s.char_in_field) <= 32'(mfc)) begin
                s.degree_accum[k] = '0;
                s.minute_accum[k] = '0;
            end
        end
        return s;
    endfunction

    function automatic pstate_t field_char(input pstate_t si, input logic [7:0] c,
                                           input int frac_kept);
        pstate_t     s;
        logic        k;
        logic        digit;
        logic [3:0]  d;
        logic [11:0] nd;
        logic [3:0]  q;
        logic [6:0]  m_rem;
        logic [2:0]  slot;
        logic        is_num;
        logic [23:0] v;
        s     = si;
        k     = (s.field_index == FLD_LON) || (s.field_index == FLD_EW);
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        d     = 4'(c - CH_ZERO);
        nd    = '0;
        q     = '0;
        m_rem = '0;
        slot  = '0;
        is_num = 1'b0;
        v     = '0;
        case (s.field_index)
            FLD_HEADER: begin
                if (s.char_in_field >= 5'd6)
                    s.header_ok = 1'b0;
                else if (HDR_TEXT[s.char_in_field[2:0]] != c)
                    s.header_ok = 1'b0;
            end
            FLD_STATUS: s.status_ok = (s.char_in_field == 5'd0) && (c == CH_A);
            FLD_LAT, FLD_LON: begin
                if (digit) begin
                    if (!s.point_seen) begin
                        q  = div10(s.minute_accum[k][6:0]);
                        nd = s.degree_accum[k] * 4'd10 + 12'(q);
                        s.degree_accum[k] = (nd > 12'd255) ? 8'd255 : nd[7:0];
                        m_rem = s.minute_accum[k][6:0] - 7'(q) * 7'd10;
                        s.minute_accum[k] = 20'(m_rem) * 20'd10 + 20'(d);
                    end else if (32'(s.fraction_digits) < 32'(frac_kept)) begin
                        s.minute_accum[k]  = 20'(s.minute_accum[k] * 4'd10 + 20'(d));
                        s.fraction_digits  = s.fraction_digits + 3'd1;
                    end
                end else if (c == CH_POINT) begin
                    s.point_seen = 1'b1;
                end
            end
            FLD_NS: s.hemisphere_neg[0] = (s.char_in_field == 5'd0) && (c == CH_S);
            FLD_EW: s.hemisphere_neg[1] = (s.char_in_field == 5'd0) && (c == CH_W);
            FLD_UTC:    begin slot = 3'd0; is_num = 1'b1; end
            FLD_SPEED:  begin slot = 3'd1; is_num = 1'b1; end
            FLD_COURSE: begin slot = 3'd2; is_num = 1'b1; end
            FLD_DATE:   begin slot = 3'd3; is_num = 1'b1; end
            FLD_MAGVAR: begin slot = 3'd4; is_num = 1'b1; end
            default: ;
        endcase
        if (is_num) begin
            v = 24'(s.number_accum[slot]);
            if (digit) begin
                if (!s.point_seen) begin
                    v = NUM_HUND[slot] ? 24'(v * 4'd10 + d * 7'd100)
                                       : 24'(v * 4'd10 + 24'(d));
                end else if (NUM_HUND[slot] && s.fraction_digits < 3'd2) begin
                    v = (s.fraction_digits == 3'd0) ? 24'(v + d * 4'd10) : v + 24'(d);
                    s.fraction_digits = s.fraction_digits + 3'd1;
                end
                s.number_accum[slot] = (v > 24'(NUM_CAP[slot])) ? NUM_CAP[slot] : v[19:0];
            end else if (c == CH_POINT) begin
                s.point_seen = 1'b1;
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* design/nrmc_field_parser.sv */
// ----------------------------------------------------------------------------
// nrmc_field_parser
// Per-character field state of the sentence; registers one record at the
// end of each line.
// ----------------------------------------------------------------------------
`default_nettype none

module nrmc_field_parser #(
    parameter int MINUTE_FIELD_CHARS = 7,
    parameter int MAX_FIELD_CHARS    = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  wire  [7:0]           char_byte,
    input  wire                  end_of_line,
    input  wire                  advance,
    output logic                 rec_valid,
    output nrmc_pkg::record_t    rec
);
    import nrmc_pkg::*;

    localparam int FracKept = (MINUTE_FIELD_CHARS < 3) ? 0 :
                              ((MINUTE_FIELD_CHARS > 7) ? 4 : MINUTE_FIELD_CHARS - 3);

    pstate_t state_reg, state_next;
    pstate_t s1, s2;
    record_t rec_reg, rec_next;
    logic    rec_valid_reg, rec_valid_next;

    always_comb
    begin
        s1 = state_reg;
        if (!s1.after_star) begin
            if (char_byte == CH_STAR)
                s1.after_star = 1'b1;
            else if (char_byte != CH_DOLLAR)
                s1.running_xor = s1.running_xor ^ char_byte;
        end
        if (char_byte == CH_COMMA) begin
            s1 = field_end(s1, MINUTE_FIELD_CHARS);
            if (s1.field_index < FLD_MAX)
                s1.field_index = s1.field_index + 4'd1;
            s1.char_in_field   = '0;
            s1.point_seen      = 1'b0;
            s1.fraction_digits = '0;
        end else if (32'(s1.char_in_field) < 32'(MAX_FIELD_CHARS)) begin
            s1 = field_char(s1, char_byte, FracKept);
            s1.char_in_field = s1.char_in_field + 5'd1;
        end
        s2 = field_end(s1, MINUTE_FIELD_CHARS);

        rec_next.valid         = s2.header_ok && s2.status_ok && (&s2.coord_ok);
        rec_next.utc_time      = s2.number_accum[0][17:0];
        rec_next.lat.deg       = s2.degree_accum[0];
        rec_next.lat.minute    = s2.minute_accum[0];
        rec_next.lat.frac_digits = s2.coord_frac[0];
        rec_next.lat.neg       = s2.hemisphere_neg[0];
        rec_next.lon.deg       = s2.degree_accum[1];
        rec_next.lon.minute    = s2.minute_accum[1];
        rec_next.lon.frac_digits = s2.coord_frac[1];
        rec_next.lon.neg       = s2.hemisphere_neg[1];
        rec_next.speed_knots   = s2.number_accum[1][16:0];
        rec_next.true_course   = s2.number_accum[2][15:0];
        rec_next.date_value    = s2.number_accum[3][18:0];
        rec_next.mag_variation = s2.number_accum[4][14:0];
        rec_next.checksum      = s2.running_xor;

        state_next     = state_reg;
        rec_valid_next = advance ? 1'b0 : rec_valid_reg;
        if (accept) begin
            state_next = end_of_line ? clear_state() : s1;
            rec_valid_next = end_of_line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= clear_state();
            rec_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && end_of_line)
            rec_reg <= rec_next;
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

`default_nettype wire

/* design/nrmc_coord_convert.sv */
// ----------------------------------------------------------------------------
// nrmc_coord_convert
// Three-stage conversion of degrees and minutes to 1e-7 degree units,
// rounded, saturated and signed by hemisphere.
// ----------------------------------------------------------------------------
`default_nettype none

module nrmc_coord_convert #(
    parameter logic [31:0] LIMIT = 32'd900000000
) (
    input  wire                 clk,
    input  wire                 advance,
    input  nrmc_pkg::coord_t    coord,
    output logic [31:0]         value
);
    import nrmc_pkg::*;

    logic [29:0] min_a_reg;
    logic [31:0] deg_a_reg;
    logic        neg_a_reg;
    logic [31:0] deg_b_reg;
    logic [24:0] quo_b_reg;
    logic        neg_b_reg;
    logic [31:0] value_reg;

    logic [43:0] min_prod;
    logic [31:0] deg_prod;
    logic [29:0] min_round;
    logic [60:0] quo_prod;
    logic [32:0] sum;
    logic [31:0] sat;

    always_comb
    begin
        min_prod  = coord.minute * minute_scale(coord.frac_digits);
        deg_prod  = coord.deg * DEG_SCALE;
        min_round = min_a_reg + 30'd30;
        quo_prod  = min_round * RECIP_60;
        sum       = 33'(deg_b_reg) + 33'(quo_b_reg);
        sat       = (sum > 33'(LIMIT)) ? LIMIT : sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            min_a_reg <= min_prod[29:0];
            deg_a_reg <= deg_prod;
            neg_a_reg <= coord.neg;
            deg_b_reg <= deg_a_reg;
            quo_b_reg <= quo_prod[RECIP_SHIFT +: 25];
            neg_b_reg <= neg_a_reg;
            value_reg <= neg_b_reg ? 32'(0) - sat : sat;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

/* design/nmea_rmc_sentence_parser.sv */
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser
// Byte-stream parser of NMEA RMC sentences giving one record per line.
// ----------------------------------------------------------------------------
// The input stream carries one sentence character per item in s_axis_tdata,
// with s_axis_tlast high on the last character of the line. Each character
// updates the field state in the same cycle it is accepted, so one item can
// be taken in every cycle while the pipeline advances.
// The output stream gives one record item for every line. record_valid
// travels in m_axis_tuser; when it is low, every field but the checksum is
// zero. The record of a line is registered at the edge that accepted its
// last character, and three stages follow for the coordinate conversion
// (minute scaling, division by 60 through a reciprocal multiply, then
// degree add with saturation and sign), the last of which is the output
// register that drives m_axis_tvalid.
// The whole pipeline advances when the output register is empty or taken,
// so a stalled receiver holds the record and s_axis_tready follows
// m_axis_tready while a record waits. Sustained throughput is one item
// per cycle while the receiver does not stall.
// Reset clears the sentence state and empties the pipeline; no record is
// pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_rmc_sentence_parser #(
    parameter int MINUTE_FIELD_CHARS = nrmc_pkg::MINUTE_FIELD_CHARS_DEF,
    parameter int MAX_FIELD_CHARS    = nrmc_pkg::MAX_FIELD_CHARS_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // char_byte
    input  wire          s_axis_tlast,   // end_of_line
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // utc_time, latitude, longitude, speed_knots, true_course, date_value,
    // mag_variation, computed_checksum, then four zero bits
    output logic [159:0] m_axis_tdata,
    output logic [0:0]   m_axis_tuser    // record_valid
);
    import nrmc_pkg::*;

    logic        advance;
    logic        accept;
    logic        rec_valid;
    record_t     rec;
    record_t     rec_a_reg, rec_b_reg, out_reg;
    logic        va_reg, vb_reg, out_valid_reg;
    logic [31:0] lat_value, lon_value;

    // The pipeline moves only when the output register can take a record.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;

    nrmc_field_parser #(
        .MINUTE_FIELD_CHARS(MINUTE_FIELD_CHARS),
        .MAX_FIELD_CHARS   (MAX_FIELD_CHARS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .char_byte  (s_axis_tdata),
        .end_of_line(s_axis_tlast),
        .advance    (advance),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    nrmc_coord_convert #(.LIMIT(LAT_LIMIT)) u_lat (
        .clk    (clk),
        .advance(advance),
        .coord  (rec.lat),
        .value  (lat_value)
    );

    nrmc_coord_convert #(.LIMIT(LON_LIMIT)) u_lon (
        .clk    (clk),
        .advance(advance),
        .coord  (rec.lon),
        .value  (lon_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            va_reg        <= rec_valid;
            vb_reg        <= va_reg;
            out_valid_reg <= vb_reg;
        end
    end

    // The scalar fields ride along with the coordinate stages.
    always_ff @(posedge clk)
    begin
        if (advance) begin
            rec_a_reg <= rec;
            rec_b_reg <= rec_a_reg;
            out_reg   <= rec_b_reg;
        end
    end

    logic ok;
    assign ok = out_reg.valid;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.valid;
    assign m_axis_tdata  = {4'b0000,
                            out_reg.checksum,
                            ok ? out_reg.mag_variation : 15'd0,
                            ok ? out_reg.date_value    : 19'd0,
                            ok ? out_reg.true_course   : 16'd0,
                            ok ? out_reg.speed_knots   : 17'd0,
                            ok ? lon_value             : 32'd0,
                            ok ? lat_value[30:0]       : 31'd0,
                            ok ? out_reg.utc_time      : 18'd0};

endmodule

`default_nettype wire

/* bench/nmea_rmc_sentence_parser_tb.sv */
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser_tb
// Self-checking bench for the RMC sentence parser: sentences go in as one
// character per item, and every record that comes out is compared field by
// field with a record predicted inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_rmc_sentence_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nrmc_pkg::*;

    // Coordinates keep four fraction digits of the minutes with the default
    // minute field length of seven characters.
    localparam int MIN_CHARS   = MINUTE_FIELD_CHARS_DEF;
    localparam int FIELD_CHARS = MAX_FIELD_CHARS_DEF;
    localparam int FRAC_KEEP   = (MIN_CHARS < 3) ? 0 : ((MIN_CHARS > 7) ? 4 : MIN_CHARS - 3);
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 12;

    typedef struct {
        bit        valid;
        bit [17:0] utc;
        bit [30:0] lat;
        bit [31:0] lon;
        bit [16:0] speed;
        bit [15:0] course;
        bit [18:0] date;
        bit [14:0] magvar;
        bit [7:0]  cksum;
    } rmc_record_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    nmea_rmc_sentence_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Idle and stall odds in percent, changed per phase by the test tasks.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    // When nonzero, the receiver holds tready low for this many cycles.
    int unsigned recv_hold_req;

    rmc_record_t pending_records[$];
    int unsigned error_count;
    int unsigned chars_sent;
    int unsigned records_seen;
    int unsigned idle_cycles;

    // Shadow copy of the parser's sentence state.
    int unsigned fld_idx;
    int unsigned fld_pos;
    bit          hdr_good;
    bit          stat_good;
    bit [7:0]    xor_sum;
    bit          star_seen;
    int unsigned deg_acc[2];
    int unsigned min_acc[2];
    int unsigned frac_cnt;
    bit          dot_seen;
    int unsigned num_acc[5];
    bit          south_west[2];
    bit          coord_long[2];

    function automatic void clear_sentence_state();
        fld_idx    = 0;
        fld_pos    = 0;
        hdr_good   = 1'b1;
        stat_good  = 1'b0;
        xor_sum    = '0;
        star_seen  = 1'b0;
        frac_cnt   = 0;
        dot_seen   = 1'b0;
        for (int k = 0; k < 2; k++)
        begin
            deg_acc[k]    = 0;
            min_acc[k]    = 0;
            south_west[k] = 1'b0;
            coord_long[k] = 1'b0;
        end
        for (int k = 0; k < 5; k++)
            num_acc[k] = 0;
    endfunction

    function automatic bit is_digit(input bit [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Numeric slot of a field: UTC, speed, course, date, variation; -1 if none.
    function automatic int numeric_slot(input int unsigned f);
        case (f)
            FLD_UTC:    return 0;
            FLD_SPEED:  return 1;
            FLD_COURSE: return 2;
            FLD_DATE:   return 3;
            FLD_MAGVAR: return 4;
            default:    return -1;
        endcase
    endfunction

    function automatic void parse_field_char(input bit [7:0] c);
        int unsigned d;
        int unsigned nd;
        int unsigned v;
        int unsigned cap;
        int          slot;
        bit          hund;
        int          k;
        d = c - CH_ZERO;
        k = (fld_idx == FLD_LON || fld_idx == FLD_EW) ? 1 : 0;
        if (fld_idx == FLD_HEADER)
        begin
            if (fld_pos >= 6 || HDR_TEXT[fld_pos] != c)
                hdr_good = 1'b0;
        end
        else if (fld_idx == FLD_STATUS)
            stat_good = (fld_pos == 0) && (c == CH_A);
        else if (fld_idx == FLD_LAT || fld_idx == FLD_LON)
        begin
            if (is_digit(c))
            begin
                if (!dot_seen)
                begin
                    // The last two integer digits are minutes; older ones roll into degrees.
                    nd         = deg_acc[k] * 10 + min_acc[k] / 10;
                    deg_acc[k] = (nd > 255) ? 255 : nd;
                    min_acc[k] = (min_acc[k] % 10) * 10 + d;
                end
                else if (frac_cnt < FRAC_KEEP)
                begin
                    min_acc[k] = min_acc[k] * 10 + d;
                    frac_cnt++;
                end
            end
            else if (c == CH_POINT)
                dot_seen = 1'b1;
        end
        else if (fld_idx == FLD_NS)
            south_west[0] = (fld_pos == 0) && (c == CH_S);
        else if (fld_idx == FLD_EW)
            south_west[1] = (fld_pos == 0) && (c == CH_W);
        else
        begin
            slot = numeric_slot(fld_idx);
            if (slot >= 0)
            begin
                hund = (slot == 1 || slot == 2 || slot == 4);
                cap  = (slot == 0) ? 262143 : (slot == 1) ? 99999 : (slot == 2) ? 36000 :
                       (slot == 3) ? 524287 : 18000;
                v = num_acc[slot];
                if (is_digit(c))
                begin
                    if (!dot_seen)
                        v = hund ? v * 10 + d * 100 : v * 10 + d;
                    else if (hund && frac_cnt < 2)
                    begin
                        v += (frac_cnt == 0) ? d * 10 : d;
                        frac_cnt++;
                    end
                    num_acc[slot] = (v > cap) ? cap : v;
                end
                else if (c == CH_POINT)
                    dot_seen = 1'b1;
            end
        end
    endfunction

    function automatic void close_field();
        int k;
        if (fld_idx == FLD_HEADER && fld_pos != 6)
            hdr_good = 1'b0;
        if (fld_idx == FLD_STATUS && fld_pos != 1)
            stat_good = 1'b0;
        if (fld_idx == FLD_LAT || fld_idx == FLD_LON)
        begin
            k = (fld_idx == FLD_LON) ? 1 : 0;
            coord_long[k] = (fld_pos >= MIN_CHARS);
            for (int i = frac_cnt; i < FRAC_KEEP; i++)
                min_acc[k] *= 10;
            // A coordinate no longer than the minute field reads as zero.
            if (fld_pos <= MIN_CHARS)
            begin
                deg_acc[k] = 0;
                min_acc[k] = 0;
            end
        end
    endfunction

    function automatic bit [31:0] coord_value(input int k, input longint unsigned limit);
        longint unsigned scale;
        longint unsigned v;
        scale = 1;
        for (int i = FRAC_KEEP; i < 7; i++)
            scale *= 10;
        // Degrees plus minutes/60, rounded half up, in units of 1e-7 degree.
        v = longint'(deg_acc[k]) * 10000000 + (longint'(min_acc[k]) * scale + 30) / 60;
        if (v > limit)
            v = limit;
        if (south_west[k])
            v = -v;
        return v[31:0];
    endfunction

    // Advances the shadow parser by one accepted character and queues a
    // predicted record when the character closes the line.
    function automatic void predict_char(input bit [7:0] c, input bit last);
        rmc_record_t r;
        if (!star_seen)
        begin
            if (c == CH_STAR)
                star_seen = 1'b1;
            else if (c != CH_DOLLAR)
                xor_sum ^= c;
        end
        if (c == CH_COMMA)
        begin
            close_field();
            if (fld_idx < FLD_MAX)
                fld_idx++;
            fld_pos  = 0;
            dot_seen = 1'b0;
            frac_cnt = 0;
        end
        else if (fld_pos < FIELD_CHARS)
        begin
            parse_field_char(c);
            fld_pos++;
        end
        if (!last)
            return;
        close_field();
        r       = '{default: '0};
        r.cksum = xor_sum;
        r.valid = hdr_good && stat_good && coord_long[0] && coord_long[1];
        if (r.valid)
        begin
            r.utc    = 18'(num_acc[0]);
            r.lat    = 31'(coord_value(0, LAT_LIMIT));
            r.lon    = coord_value(1, LON_LIMIT);
            r.speed  = 17'(num_acc[1]);
            r.course = 16'(num_acc[2]);
            r.date   = 19'(num_acc[3]);
            r.magvar = 15'(num_acc[4]);
        end
        pending_records = {pending_records, r};
        clear_sentence_state();
    endfunction

    // Sends one character, idling at random first, and predicts it once taken.
    task automatic send_char(input bit [7:0] c, input bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_char(c, last);
        chars_sent++;
    endtask

    task automatic send_line(input string text);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], i == text.len() - 1);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_records.size() != 0)
            @(posedge clk);
    endtask

    function automatic string digits(input int unsigned n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
        return s;
    endfunction

    // A number with the given integer digits and an optional fraction.
    function automatic string rand_number(input int unsigned ints, input int unsigned fracs);
        string s;
        s = digits(ints);
        if (fracs != 0 || $urandom_range(3) == 0)
            s = {s, ".", digits(fracs)};
        return s;
    endfunction

    // Random field text: usually well formed, sometimes with a stray byte.
    function automatic string spice(input string s);
        if ($urandom_range(19) == 0)
            s = {s, string'(8'($urandom_range(33, 126)))};
        return s;
    endfunction

    function automatic string rand_sentence();
        string s;
        string hemi[4];
        hemi = '{"N", "S", "E", "W"};
        s = ($urandom_range(9) != 0) ? "$GPRMC" : (($urandom_range(1) != 0) ? "$GPGGA" : "GPRMC");
        s = {s, ",", spice(rand_number($urandom_range(0, 7), $urandom_range(0, 3)))};
        s = {s, ",", ($urandom_range(6) != 0) ? "A" : (($urandom_range(1) != 0) ? "V" : "AA")};
        s = {s, ",", spice(rand_number($urandom_range(1, 5), $urandom_range(0, 6)))};
        s = {s, ",", hemi[$urandom_range(3)]};
        s = {s, ",", spice(rand_number($urandom_range(1, 6), $urandom_range(0, 6)))};
        s = {s, ",", hemi[$urandom_range(3)]};
        s = {s, ",", spice(rand_number($urandom_range(0, 6), $urandom_range(0, 3)))};
        s = {s, ",", spice(rand_number($urandom_range(0, 6), $urandom_range(0, 3)))};
        s = {s, ",", spice(rand_number($urandom_range(0, 7), $urandom_range(0, 2)))};
        s = {s, ",", spice(rand_number($urandom_range(0, 6), $urandom_range(0, 3)))};
        s = {s, ",", hemi[$urandom_range(3)]};
        if ($urandom_range(4) == 0)
            s = {s, ",", digits($urandom_range(0, 20))};
        if ($urandom_range(5) != 0)
            s = {s, $sformatf("*%02X", $urandom_range(255))};
        if ($urandom_range(9) == 0)
            s = {s, ","};
        return s;
    endfunction

    // Arbitrary bytes, ending with a marked last character.
    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(1, 24);
        for (int i = 0; i < n; i++)
            send_char($urandom_range(255), i == n - 1);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // A well-formed fix in the north-east with the checksum, then one in the south-west without it.
        send_line("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
        send_line("$GPRMC,235959.99,A,8959.99999,S,17959.9999,W,0.5,359.99,311299,180.0,E");
        // Saturating coordinates and numbers.
        send_line("$GPRMC,9999999,A,99999.9999,N,999999.9999,W,9999999,99999,9999999,99999");
        // Coordinates exactly at and below the minute field length, then longer ones.
        send_line("$GPRMC,1,A,1234.56,N,1234.5,E,1,2,3,4");
        send_line("$GPRMC,1,A,12345.678,S,1234.567,W,1,2,3,4");
        // Bad header, void status, wrong header length.
        send_line("$GPGGA,1,A,4807.0380,N,01131.0000,E");
        send_line("$GPRMC,1,V,4807.0380,N,01131.0000,E");
        send_line("$GPRMCX,1,A,4807.0380,N,01131.0000,E");
        // Star inside a field, stray characters and signs in numbers.
        send_line("$GPRMC,12x3-4,A,48*07.0380,N,0113.1.0000,E,+1.2.3,4..5");
        // Long field past the parse window, extra fields beyond the last.
        send_line("$GPRMC,12345678901234567890,A,4807.0380,N,01131.0000,E,1,2,3,4,W,,,,,,,,9");
        // One-character lines: empty, a lone comma, the top byte.
        send_char(CH_DOLLAR, 1'b1);
        send_char(CH_COMMA, 1'b1);
        send_char(8'hFF, 1'b1);
        // Missing fields and a trailing comma on the last character.
        send_line("$GPRMC,,A,4807.0380,N,01131.0000,");
        wait_drained();
    endtask

    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned min_chars, input int unsigned min_recs);
        int unsigned start_chars;
        int unsigned start_recs;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start_chars    = chars_sent;
        start_recs     = records_seen + pending_records.size();
        while (chars_sent - start_chars < min_chars ||
               records_seen + pending_records.size() - start_recs < min_recs)
        begin
            if ($urandom_range(4) != 0)
                send_line(rand_sentence());
            else
                send_noise();
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 90, 2);
        run_random_phase(56, 0, 90, 2);
        run_random_phase(0, 56, 90, 2);
        run_random_phase(30, 30, 90, 2);
        wait_drained();
    endtask

    // The receiver stops for a long stretch while short lines keep coming, so
    // the pipeline fills and tready on the input drops; then the sender waits
    // for every record before going on.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold_req  = 300;
        for (int i = 0; i < 10; i++)
            send_line("$GPRMC,1,A,4807.0380,S,01131.0000,W,1.5");
        wait_drained();
        send_line(rand_sentence());
        wait_drained();
    endtask

    // Result side: random stalls, long hold on request, and the field checks.
    always @(posedge clk)
    begin
        rmc_record_t exp_rec;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                records_seen++;
                if (pending_records.size() == 0)
                begin
                    $error("record with no expected record waiting");
                    error_count++;
                end
                else
                begin
                    exp_rec = pending_records.pop_front();
                    if (m_axis_tuser[0] !== exp_rec.valid)
                    begin
                        $error("record_valid: expected %0d, got %0d", exp_rec.valid,
                               m_axis_tuser[0]);
                        error_count++;
                    end
                    if (m_axis_tdata[17:0] !== exp_rec.utc)
                    begin
                        $error("utc_time: expected %0d, got %0d", exp_rec.utc,
                               m_axis_tdata[17:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[48:18] !== exp_rec.lat)
                    begin
                        $error("latitude: expected %0d, got %0d", $signed(exp_rec.lat),
                               $signed(m_axis_tdata[48:18]));
                        error_count++;
                    end
                    if (m_axis_tdata[80:49] !== exp_rec.lon)
                    begin
                        $error("longitude: expected %0d, got %0d", $signed(exp_rec.lon),
                               $signed(m_axis_tdata[80:49]));
                        error_count++;
                    end
                    if (m_axis_tdata[97:81] !== exp_rec.speed)
                    begin
                        $error("speed_knots: expected %0d, got %0d", exp_rec.speed,
                               m_axis_tdata[97:81]);
                        error_count++;
                    end
                    if (m_axis_tdata[113:98] !== exp_rec.course)
                    begin
                        $error("true_course: expected %0d, got %0d", exp_rec.course,
                               m_axis_tdata[113:98]);
                        error_count++;
                    end
                    if (m_axis_tdata[132:114] !== exp_rec.date)
                    begin
                        $error("date_value: expected %0d, got %0d", exp_rec.date,
                               m_axis_tdata[132:114]);
                        error_count++;
                    end
                    if (m_axis_tdata[147:133] !== exp_rec.magvar)
                    begin
                        $error("mag_variation: expected %0d, got %0d", exp_rec.magvar,
                               m_axis_tdata[147:133]);
                        error_count++;
                    end
                    if (m_axis_tdata[155:148] !== exp_rec.cksum)
                    begin
                        $error("computed_checksum: expected %0h, got %0h", exp_rec.cksum,
                               m_axis_tdata[155:148]);
                        error_count++;
                    end
                end
            end
            if (recv_hold_req != 0)
            begin
                recv_hold_req--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run if nothing is accepted on either side for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("nmea_rmc_sentence_parser verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold_req  = 0;
        error_count    = 0;
        chars_sent     = 0;
        records_seen   = 0;
        idle_cycles    = 0;
        clear_sentence_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_traffic();

        // Let any stray record show up before the verdict.
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_records.size() == 0)
            $display("nmea_rmc_sentence_parser verification clean");
        else
            $display("nmea_rmc_sentence_parser verification failed");
        $finish;
    end

endmodule

`default_nettype wire
